/* sv/aat_pkg.sv */
package aat_pkg;

  // Field widths and fixed-point layout
  localparam int COORD_W = 24;                  // signed Q12.12 coordinate
  localparam int SIZE_W  = COORD_W - 1;         // unsigned Q11.12 size
  localparam int COEF_W  = 16;                  // signed Q4.12 coefficient
  localparam int FRAC_W  = 12;
  localparam int ROW_W   = 3 * COEF_W;          // one packed matrix row
  localparam int CFG_W   = ROW_W;               // widest register
  localparam int CFG_IDX_W = 3;

  // Datapath widths
  localparam int PROD_W  = COORD_W + COEF_W;    // signed center product
  localparam int CSUM_W  = PROD_W + 2;          // sum of three products
  localparam int CT_W    = CSUM_W - FRAC_W + 1; // shifted sum plus translation
  localparam int EPROD_W = SIZE_W + COEF_W;     // size times |coef|
  localparam int ESUM_W  = EPROD_W + 2;
  localparam int ESH_W   = ESUM_W - FRAC_W;
  localparam int HALF_W  = SIZE_W - 1;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [SIZE_W-1:0]         SIZE_MAX  = {SIZE_W{1'b1}};

  // 1.0 in Q4.12, placed on the diagonal at reset
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_W;
  localparam logic [ROW_W-1:0]  ROW0_RST = ROW_W'(COEF_ONE);
  localparam logic [ROW_W-1:0]  ROW1_RST = ROW_W'(COEF_ONE) << COEF_W;
  localparam logic [ROW_W-1:0]  ROW2_RST = ROW_W'(COEF_ONE) << (2 * COEF_W);

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0    = 3'd0,
    REG_ROW1    = 3'd1,
    REG_ROW2    = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [SIZE_W-1:0]         extent_x;
    logic [SIZE_W-1:0]         extent_y;
    logic [SIZE_W-1:0]         extent_z;
  } box_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] new_center_x;
    logic signed [COORD_W-1:0] new_center_y;
    logic signed [COORD_W-1:0] new_center_z;
    logic [SIZE_W-1:0]         new_extent_x;
    logic [SIZE_W-1:0]         new_extent_y;
    logic [SIZE_W-1:0]         new_extent_z;
    logic signed [COORD_W-1:0] low_x;
    logic signed [COORD_W-1:0] low_y;
    logic signed [COORD_W-1:0] low_z;
    logic signed [COORD_W-1:0] high_x;
    logic signed [COORD_W-1:0] high_y;
    logic signed [COORD_W-1:0] high_z;
  } box_out_t;

  // Per-stage load enables, stage 1 at the input, stage 4 the output register
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
  } pipe_ctl_t;

  // Result of one output axis
  typedef struct packed {
    logic signed [COORD_W-1:0] center;
    logic [SIZE_W-1:0]         extent;
    logic signed [COORD_W-1:0] low;
    logic signed [COORD_W-1:0] high;
  } lane_res_t;

  // Clamp a wide signed value to the coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [CT_W-1:0] v);
    logic [CT_W-COORD_W:0] top;
    begin
      top = v[CT_W-1:COORD_W-1];
      if (top == '0 || top == '1) begin
        return v[COORD_W-1:0];
      end else if (v[CT_W-1]) begin
        return COORD_MIN;
      end else begin
        return COORD_MAX;
      end
    end
  endfunction

  // Clamp a non-negative value to the size range
  function automatic logic [SIZE_W-1:0] sat_size(input logic [ESH_W-1:0] v);
    begin
      if (|v[ESH_W-1:SIZE_W]) begin
        return SIZE_MAX;
      end else begin
        return v[SIZE_W-1:0];
      end
    end
  endfunction

  // Magnitude of a coefficient; the most negative code maps to 2^(COEF_W-1)
  function automatic logic [COEF_W-1:0] coef_abs(input logic [COEF_W-1:0] m);
    begin
      if (m[COEF_W-1]) begin
        return ~m + COEF_W'(1);
      end else begin
        return m;
      end
    end
  endfunction

endpackage

/* sv/aat_lane.sv */
// One output axis: center and size for column j of the matrix, then corners.
module aat_lane (
  input  logic                                        clk,
  input  aat_pkg::pipe_ctl_t                          ctl,
  input  logic [2:0][aat_pkg::COORD_W-1:0]            center,
  input  logic [2:0][aat_pkg::SIZE_W-1:0]             extent,
  input  logic [2:0][aat_pkg::COEF_W-1:0]             coef,
  input  logic signed [aat_pkg::COORD_W-1:0]          shift,
  output aat_pkg::lane_res_t                          res
);

  // Stage 1: products
  logic signed [aat_pkg::PROD_W-1:0]  cp_r   [3];
  logic signed [aat_pkg::PROD_W-1:0]  cp_nxt [3];
  logic [aat_pkg::EPROD_W-1:0]        ep_r   [3];
  logic [aat_pkg::EPROD_W-1:0]        ep_nxt [3];

  always_comb begin
    logic signed [aat_pkg::COORD_W-1:0] c;
    logic signed [aat_pkg::COEF_W-1:0]  m;
    logic [aat_pkg::EPROD_W-1:0]        e_w;
    logic [aat_pkg::EPROD_W-1:0]        a_w;
    for (int i = 0; i < 3; i++) begin
      c         = center[i];
      m         = coef[i];
      cp_nxt[i] = c * m;
      e_w       = aat_pkg::EPROD_W'(extent[i]);
      a_w       = aat_pkg::EPROD_W'(aat_pkg::coef_abs(coef[i]));
      ep_nxt[i] = e_w * a_w;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      for (int i = 0; i < 3; i++) begin
        cp_r[i] <= cp_nxt[i];
        ep_r[i] <= ep_nxt[i];
      end
    end
  end

  // Stage 2: sums of the three products
  logic signed [aat_pkg::CSUM_W-1:0] csum_r, csum_nxt;
  logic [aat_pkg::ESUM_W-1:0]        esum_r, esum_nxt;

  always_comb begin
    csum_nxt = aat_pkg::CSUM_W'(cp_r[0]) + aat_pkg::CSUM_W'(cp_r[1])
             + aat_pkg::CSUM_W'(cp_r[2]);
    esum_nxt = aat_pkg::ESUM_W'(ep_r[0]) + aat_pkg::ESUM_W'(ep_r[1])
             + aat_pkg::ESUM_W'(ep_r[2]);
  end

  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      csum_r <= csum_nxt;
      esum_r <= esum_nxt;
    end
  end

  // Stage 3: floor shift, translate, saturate
  logic signed [aat_pkg::COORD_W-1:0] nc_r, nc_nxt;
  logic [aat_pkg::SIZE_W-1:0]         ne_r, ne_nxt;

  always_comb begin
    logic signed [aat_pkg::CT_W-1:0] csh;
    logic signed [aat_pkg::CT_W-1:0] shx;
    logic [aat_pkg::ESH_W-1:0]       esh;
    csh    = aat_pkg::CT_W'(csum_r >>> aat_pkg::FRAC_W);
    shx    = aat_pkg::CT_W'(shift);
    nc_nxt = aat_pkg::sat_coord(csh + shx);
    esh    = aat_pkg::ESH_W'(esum_r >> aat_pkg::FRAC_W);
    ne_nxt = aat_pkg::sat_size(esh);
  end

  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      nc_r <= nc_nxt;
      ne_r <= ne_nxt;
    end
  end

  // Stage 4: corners from half size, output register
  aat_pkg::lane_res_t res_r, res_nxt;

  always_comb begin
    logic signed [aat_pkg::CT_W-1:0] ncx;
    logic signed [aat_pkg::CT_W-1:0] hx;
    ncx            = aat_pkg::CT_W'(nc_r);
    hx             = aat_pkg::CT_W'(ne_r[aat_pkg::SIZE_W-1:1]);
    res_nxt.center = nc_r;
    res_nxt.extent = ne_r;
    res_nxt.low    = aat_pkg::sat_coord(ncx - hx);
    res_nxt.high   = aat_pkg::sat_coord(ncx + hx);
  end

  always_ff @(posedge clk) begin
    if (ctl.en4) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

/* sv/aabb_affine_transform.sv */
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   aat_pkg::box_in_t  (center, full size)
// out_      output     out_valid/out_stall aat_pkg::box_out_t (center, size, corners)
// cfg_      input      cfg_we              cfg_idx, cfg_data (matrix rows, translation)
//
// Four register stages: products, sums, shift/translate/saturate, corners.
// One box per cycle while the output is not stalled; out_valid rises once a box
// has been loaded into the corners stage, the output register.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// are squeezed out while the output is stalled.
// Synchronous active-low reset empties the pipeline and loads the identity
// matrix with zero translation.
module aabb_affine_transform (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  aat_pkg::box_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output aat_pkg::box_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [aat_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [aat_pkg::CFG_W-1:0]         cfg_data
);

  // Configuration registers
  logic [aat_pkg::ROW_W-1:0]          row_r   [3];
  logic signed [aat_pkg::COORD_W-1:0] shift_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0]   <= aat_pkg::ROW0_RST;
      row_r[1]   <= aat_pkg::ROW1_RST;
      row_r[2]   <= aat_pkg::ROW2_RST;
      shift_r[0] <= '0;
      shift_r[1] <= '0;
      shift_r[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        aat_pkg::REG_ROW0:    row_r[0]   <= cfg_data[aat_pkg::ROW_W-1:0];
        aat_pkg::REG_ROW1:    row_r[1]   <= cfg_data[aat_pkg::ROW_W-1:0];
        aat_pkg::REG_ROW2:    row_r[2]   <= cfg_data[aat_pkg::ROW_W-1:0];
        aat_pkg::REG_SHIFT_X: shift_r[0] <= cfg_data[aat_pkg::COORD_W-1:0];
        aat_pkg::REG_SHIFT_Y: shift_r[1] <= cfg_data[aat_pkg::COORD_W-1:0];
        aat_pkg::REG_SHIFT_Z: shift_r[2] <= cfg_data[aat_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline valid bits and per-stage load enables
  logic [3:0]         vld_r, vld_nxt;
  aat_pkg::pipe_ctl_t ctl;

  always_comb begin
    ctl.en4 = !vld_r[3] || !out_stall;
    ctl.en3 = !vld_r[2] || ctl.en4;
    ctl.en2 = !vld_r[1] || ctl.en3;
    ctl.en1 = !vld_r[0] || ctl.en2;
    vld_nxt[0] = ctl.en1 ? in_valid : vld_r[0];
    vld_nxt[1] = ctl.en2 ? vld_r[0] : vld_r[1];
    vld_nxt[2] = ctl.en3 ? vld_r[1] : vld_r[2];
    vld_nxt[3] = ctl.en4 ? vld_r[2] : vld_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !ctl.en1;
  assign out_valid = vld_r[3];

  // Input vectors, index 0 is x
  logic [2:0][aat_pkg::COORD_W-1:0] center;
  logic [2:0][aat_pkg::SIZE_W-1:0]  extent;

  assign center = {in_data.center_z, in_data.center_y, in_data.center_x};
  assign extent = {in_data.extent_z, in_data.extent_y, in_data.extent_x};

  // One lane per output axis, fed by one column of the matrix
  aat_pkg::lane_res_t res [3];

  for (genvar j = 0; j < 3; j++) begin : g_lane
    logic [2:0][aat_pkg::COEF_W-1:0] col;

    for (genvar i = 0; i < 3; i++) begin : g_col
      assign col[i] = row_r[i][j*aat_pkg::COEF_W +: aat_pkg::COEF_W];
    end

    aat_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .center (center),
      .extent (extent),
      .coef   (col),
      .shift  (shift_r[j]),
      .res    (res[j])
    );
  end

  // Result assembly
  always_comb begin
    out_data.new_center_x = res[0].center;
    out_data.new_center_y = res[1].center;
    out_data.new_center_z = res[2].center;
    out_data.new_extent_x = res[0].extent;
    out_data.new_extent_y = res[1].extent;
    out_data.new_extent_z = res[2].extent;
    out_data.low_x        = res[0].low;
    out_data.low_y        = res[1].low;
    out_data.low_z        = res[2].low;
    out_data.high_x       = res[0].high;
    out_data.high_y       = res[1].high;
    out_data.high_z       = res[2].high;
  end

  // Input is held off only when every stage is occupied
  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (vld_r == 4'b1111))
    else $error("input stalled with an empty pipeline stage");

  // Corners bracket the center
  a_corner_order : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.low_x <= out_data.new_center_x)
               && (out_data.new_center_x <= out_data.high_x)
               && (out_data.low_y <= out_data.new_center_y)
               && (out_data.new_center_y <= out_data.high_y)
               && (out_data.low_z <= out_data.new_center_z)
               && (out_data.new_center_z <= out_data.high_z))
    else $error("corner outside of center ordering");

  // Reset empties the pipeline
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> (vld_r == 4'b0000))
    else $error("pipeline not empty after reset");

endmodule

/* test/tb_aabb_affine_transform.sv */
module tb_aabb_affine_transform;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  CYCLE_LIMIT  = 200000;
  localparam int  HOLD_CYCLES  = 80;
  localparam int  DRAIN_CYCLES = 12;
  localparam int  RANDOM_BOXES = 105;
  localparam logic [aat_pkg::CFG_IDX_W-1:0] IDX_UNMAPPED_A = 3'd6;
  localparam logic [aat_pkg::CFG_IDX_W-1:0] IDX_UNMAPPED_B = 3'd7;
  localparam longint COORD_HI = (longint'(1) << (aat_pkg::COORD_W - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;
  localparam longint SIZE_HI  = (longint'(1) << aat_pkg::SIZE_W) - 1;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  aat_pkg::box_in_t              in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  aat_pkg::box_out_t             out_data;
  logic                          cfg_we = 1'b0;
  logic [aat_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [aat_pkg::CFG_W-1:0]     cfg_data = '0;

  // Shadow copy of the transform registers
  logic [aat_pkg::ROW_W-1:0]          row_cfg [3];
  logic signed [aat_pkg::COORD_W-1:0] shift_cfg [3];

  aat_pkg::box_in_t  pending_boxes [$];
  aat_pkg::box_out_t expected_boxes [$];

  bit  box_taken;
  bit  pressure_on;
  bit  hold_done;
  int  hold_left;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  fail_count;
  int  boxes_in;
  int  boxes_out;
  int  stall_cycles;
  int  config_sets;
  int  cycle_count;

  string field_names [12] = '{"new_center_x", "new_center_y", "new_center_z",
                              "new_extent_x", "new_extent_y", "new_extent_z",
                              "low_x", "low_y", "low_z", "high_x", "high_y", "high_z"};

  aabb_affine_transform DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Transform predictor
  function automatic longint clamp_coord(longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  function automatic longint coef_at(int row, int col);
    logic signed [aat_pkg::COEF_W-1:0] c;
    c = row_cfg[row][col*aat_pkg::COEF_W +: aat_pkg::COEF_W];
    return c;
  endfunction

  function automatic aat_pkg::box_out_t transform_box(aat_pkg::box_in_t b);
    longint            ctr [3];
    longint            ext [3];
    longint            nc [3];
    longint            ne [3];
    longint            lo [3];
    longint            hi [3];
    longint            csum;
    longint            esum;
    longint            m;
    aat_pkg::box_out_t r;
    ctr[0] = b.center_x;
    ctr[1] = b.center_y;
    ctr[2] = b.center_z;
    ext[0] = b.extent_x;
    ext[1] = b.extent_y;
    ext[2] = b.extent_z;
    for (int j = 0; j < 3; j++) begin
      csum = 0;
      esum = 0;
      for (int i = 0; i < 3; i++) begin
        m = coef_at(i, j);
        csum += ctr[i] * m;
        esum += ext[i] * ((m < 0) ? -m : m);
      end
      // center floors toward minus infinity, size truncates
      nc[j] = clamp_coord((csum >>> aat_pkg::FRAC_W) + longint'(shift_cfg[j]));
      ne[j] = esum >>> aat_pkg::FRAC_W;
      if (ne[j] > SIZE_HI) ne[j] = SIZE_HI;
      lo[j] = clamp_coord(nc[j] - (ne[j] >>> 1));
      hi[j] = clamp_coord(nc[j] + (ne[j] >>> 1));
    end
    r.new_center_x = aat_pkg::COORD_W'(nc[0]);
    r.new_center_y = aat_pkg::COORD_W'(nc[1]);
    r.new_center_z = aat_pkg::COORD_W'(nc[2]);
    r.new_extent_x = aat_pkg::SIZE_W'(ne[0]);
    r.new_extent_y = aat_pkg::SIZE_W'(ne[1]);
    r.new_extent_z = aat_pkg::SIZE_W'(ne[2]);
    r.low_x        = aat_pkg::COORD_W'(lo[0]);
    r.low_y        = aat_pkg::COORD_W'(lo[1]);
    r.low_z        = aat_pkg::COORD_W'(lo[2]);
    r.high_x       = aat_pkg::COORD_W'(hi[0]);
    r.high_y       = aat_pkg::COORD_W'(hi[1]);
    r.high_z       = aat_pkg::COORD_W'(hi[2]);
    return r;
  endfunction

  function automatic logic signed [63:0] field_of(aat_pkg::box_out_t b, int k);
    case (k)
      0:       return b.new_center_x;
      1:       return b.new_center_y;
      2:       return b.new_center_z;
      3:       return {1'b0, b.new_extent_x};
      4:       return {1'b0, b.new_extent_y};
      5:       return {1'b0, b.new_extent_z};
      6:       return b.low_x;
      7:       return b.low_y;
      8:       return b.low_z;
      9:       return b.high_x;
      10:      return b.high_y;
      default: return b.high_z;
    endcase
  endfunction

  // Input driver: a new transfer is offered once the previous one is taken
  always @(negedge clk) begin : drive_boxes
    logic             nxt_valid;
    aat_pkg::box_in_t nxt_data;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else if (!in_valid || box_taken) begin
      nxt_valid = 1'b0;
      if (pending_boxes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt_data  = pending_boxes.pop_front();
        nxt_valid = 1'b1;
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // Result receiver, with one long hold-off when pressure is requested
  always @(negedge clk) begin
    if (pressure_on && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor: predict on input transfers, check on output transfers
  always @(posedge clk) begin : watch_ports
    aat_pkg::box_out_t  want;
    logic signed [63:0] e_v;
    logic signed [63:0] g_v;
    box_taken = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (box_taken) begin
        expected_boxes.push_back(transform_box(in_data));
        boxes_in++;
      end
      if (in_valid && in_stall) stall_cycles++;
      if (out_valid && !out_stall) begin
        if (expected_boxes.size() == 0) begin
          $error("result transfer with no box outstanding");
          fail_count++;
        end else begin
          want = expected_boxes.pop_front();
          boxes_out++;
          for (int k = 0; k < 12; k++) begin
            e_v = field_of(want, k);
            g_v = field_of(out_data, k);
            if (e_v !== g_v) begin
              $error("%s mismatch: expected %0d, got %0d", field_names[k], e_v, g_v);
              fail_count++;
            end
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(logic [aat_pkg::CFG_IDX_W-1:0] idx,
                           logic [aat_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx) inside
      aat_pkg::REG_ROW0, aat_pkg::REG_ROW1, aat_pkg::REG_ROW2:
        row_cfg[idx] = data;
      aat_pkg::REG_SHIFT_X, aat_pkg::REG_SHIFT_Y, aat_pkg::REG_SHIFT_Z:
        shift_cfg[idx - aat_pkg::REG_SHIFT_X] = data[aat_pkg::COORD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    bit idle_now;
    idle_now = 1'b0;
    while (!idle_now) begin
      @(posedge clk);
      #1;
      idle_now = (pending_boxes.size() == 0) && !in_valid && (expected_boxes.size() == 0);
    end
  endtask

  function automatic aat_pkg::box_in_t make_box(
      logic signed [aat_pkg::COORD_W-1:0] cx, logic signed [aat_pkg::COORD_W-1:0] cy,
      logic signed [aat_pkg::COORD_W-1:0] cz, logic [aat_pkg::SIZE_W-1:0] ex,
      logic [aat_pkg::SIZE_W-1:0] ey, logic [aat_pkg::SIZE_W-1:0] ez);
    aat_pkg::box_in_t b;
    b.center_x = cx;
    b.center_y = cy;
    b.center_z = cz;
    b.extent_x = ex;
    b.extent_y = ey;
    b.extent_z = ez;
    return b;
  endfunction

  // Random content: mostly moderate values, with full range and extremes mixed in
  function automatic logic signed [aat_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return aat_pkg::COORD_MAX;
      1:       return aat_pkg::COORD_MIN;
      2, 3:    return aat_pkg::COORD_W'($urandom());
      default: return aat_pkg::COORD_W'($urandom_range(0, 1 << 19))
                      - aat_pkg::COORD_W'(1 << 18);
    endcase
  endfunction

  function automatic logic [aat_pkg::SIZE_W-1:0] rand_extent();
    case ($urandom_range(0, 9))
      0:       return aat_pkg::SIZE_MAX;
      1:       return '0;
      2, 3:    return aat_pkg::SIZE_W'($urandom());
      default: return aat_pkg::SIZE_W'($urandom_range(0, 1 << 18));
    endcase
  endfunction

  function automatic logic [aat_pkg::CFG_W-1:0] rand_row();
    logic [aat_pkg::CFG_W-1:0] r;
    case ($urandom_range(0, 3))
      0: r = aat_pkg::CFG_W'({$urandom(), $urandom()});
      1: begin
        for (int c = 0; c < 3; c++)
          r[c*aat_pkg::COEF_W +: aat_pkg::COEF_W] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      end
      default: begin
        // coefficients within +/-2.0
        for (int c = 0; c < 3; c++)
          r[c*aat_pkg::COEF_W +: aat_pkg::COEF_W] =
            aat_pkg::COEF_W'($urandom_range(0, 16384)) - aat_pkg::COEF_W'(8192);
      end
    endcase
    return r;
  endfunction

  function automatic logic [aat_pkg::CFG_W-1:0] rand_shift();
    if ($urandom_range(0, 2) == 0) return aat_pkg::CFG_W'({$urandom(), $urandom()});
    return aat_pkg::CFG_W'(aat_pkg::COORD_W'($urandom_range(0, 1 << 20))
                           - aat_pkg::COORD_W'(1 << 19));
  endfunction

  task automatic set_random_config();
    write_reg(aat_pkg::REG_ROW0, rand_row());
    write_reg(aat_pkg::REG_ROW1, rand_row());
    write_reg(aat_pkg::REG_ROW2, rand_row());
    write_reg(aat_pkg::REG_SHIFT_X, rand_shift());
    write_reg(aat_pkg::REG_SHIFT_Y, rand_shift());
    write_reg(aat_pkg::REG_SHIFT_Z, rand_shift());
    config_sets++;
  endtask

  task automatic run_random(int n_boxes);
    for (int i = 0; i < n_boxes; i++)
      pending_boxes.push_back(make_box(rand_coord(), rand_coord(), rand_coord(),
                                       rand_extent(), rand_extent(), rand_extent()));
    wait_drained();
  endtask

  // Sequence of phases
  initial begin
    row_cfg[0]   = aat_pkg::ROW0_RST;
    row_cfg[1]   = aat_pkg::ROW1_RST;
    row_cfg[2]   = aat_pkg::ROW2_RST;
    shift_cfg[0] = '0;
    shift_cfg[1] = '0;
    shift_cfg[2] = '0;
    config_sets  = 1;
    send_idle_pct = 14;
    recv_idle_pct = 61;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // writes to unmapped indexes must leave the identity transform alone
    write_reg(IDX_UNMAPPED_A, '1);
    write_reg(IDX_UNMAPPED_B, 48'h1234_5678_9ABC);

    // identity: pass-through, corner saturation, odd sizes
    pending_boxes.push_back(make_box('0, '0, '0, '0, '0, '0));
    pending_boxes.push_back(make_box(aat_pkg::COORD_MAX, aat_pkg::COORD_MAX, aat_pkg::COORD_MAX,
                                     aat_pkg::SIZE_MAX, aat_pkg::SIZE_MAX, aat_pkg::SIZE_MAX));
    pending_boxes.push_back(make_box(aat_pkg::COORD_MIN, aat_pkg::COORD_MIN, aat_pkg::COORD_MIN,
                                     aat_pkg::SIZE_MAX, aat_pkg::SIZE_MAX, aat_pkg::SIZE_MAX));
    pending_boxes.push_back(make_box(24'sd1, -24'sd1, '0, 23'd1, 23'd3, 23'd2));
    pending_boxes.push_back(make_box(24'sh123456, -24'sh0ABCDE, 24'sh000FFF,
                                     23'h2AAAAA, 23'h555555, 23'h000800));
    wait_drained();

    // most negative coefficients everywhere; junk above the translation width
    write_reg(aat_pkg::REG_ROW0, 48'h8000_8000_8000);
    write_reg(aat_pkg::REG_ROW1, 48'h8000_8000_8000);
    write_reg(aat_pkg::REG_ROW2, 48'h8000_8000_8000);
    write_reg(aat_pkg::REG_SHIFT_X, {24'hFFFFFF, 24'h7FFFFF});
    write_reg(aat_pkg::REG_SHIFT_Y, {24'hA5A5A5, 24'h800000});
    write_reg(aat_pkg::REG_SHIFT_Z, {24'hFFFFFF, 24'h000000});
    config_sets++;
    pending_boxes.push_back(make_box(aat_pkg::COORD_MAX, aat_pkg::COORD_MAX, aat_pkg::COORD_MAX,
                                     aat_pkg::SIZE_MAX, aat_pkg::SIZE_MAX, aat_pkg::SIZE_MAX));
    pending_boxes.push_back(make_box(aat_pkg::COORD_MIN, aat_pkg::COORD_MIN, aat_pkg::COORD_MIN,
                                     '0, '0, '0));
    pending_boxes.push_back(make_box('0, '0, '0, 23'd1, 23'd1, 23'd1));
    pending_boxes.push_back(make_box(aat_pkg::COORD_MAX, aat_pkg::COORD_MIN, '0,
                                     aat_pkg::SIZE_MAX, '0, 23'd1));
    pending_boxes.push_back(make_box(-24'sd1, -24'sd1, -24'sd1, 23'd2, 23'd2, 23'd2));
    wait_drained();

    // one-LSB coefficients of both signs: floor of the center, truncation of the size
    write_reg(aat_pkg::REG_ROW0, {16'h0001, 16'hFFFF, 16'h0001});
    write_reg(aat_pkg::REG_ROW1, {16'hFFFF, 16'h0001, 16'h0000});
    write_reg(aat_pkg::REG_ROW2, {16'h0001, 16'h0000, 16'hFFFF});
    write_reg(aat_pkg::REG_SHIFT_X, '0);
    write_reg(aat_pkg::REG_SHIFT_Y, 48'd1);
    write_reg(aat_pkg::REG_SHIFT_Z, {24'd0, 24'hFFFFFF});
    config_sets++;
    pending_boxes.push_back(make_box(24'sd1, '0, '0, 23'd4095, 23'd4096, 23'd8191));
    pending_boxes.push_back(make_box(-24'sd1, '0, '0, 23'd1, 23'd0, 23'd0));
    pending_boxes.push_back(make_box(24'sd4095, -24'sd4095, 24'sd1, 23'd8192, 23'd1, 23'd4097));
    pending_boxes.push_back(make_box(-24'sd4096, 24'sd4096, -24'sd1,
                                     aat_pkg::SIZE_MAX, aat_pkg::SIZE_MAX, 23'd0));
    pending_boxes.push_back(make_box(aat_pkg::COORD_MAX, aat_pkg::COORD_MIN, aat_pkg::COORD_MAX,
                                     23'd3, 23'd5, 23'd7));
    wait_drained();

    // largest positive coefficients
    write_reg(aat_pkg::REG_ROW0, 48'h7FFF_7FFF_7FFF);
    write_reg(aat_pkg::REG_ROW1, 48'h7FFF_7FFF_7FFF);
    write_reg(aat_pkg::REG_ROW2, 48'h7FFF_7FFF_7FFF);
    write_reg(aat_pkg::REG_SHIFT_X, {24'd0, 24'h800000});
    write_reg(aat_pkg::REG_SHIFT_Y, {24'd0, 24'h7FFFFF});
    write_reg(aat_pkg::REG_SHIFT_Z, {24'd0, 24'hFFFFFF});
    config_sets++;
    pending_boxes.push_back(make_box(aat_pkg::COORD_MAX, aat_pkg::COORD_MAX, aat_pkg::COORD_MAX,
                                     aat_pkg::SIZE_MAX, aat_pkg::SIZE_MAX, aat_pkg::SIZE_MAX));
    pending_boxes.push_back(make_box(aat_pkg::COORD_MIN, aat_pkg::COORD_MIN, aat_pkg::COORD_MIN,
                                     aat_pkg::SIZE_MAX, aat_pkg::SIZE_MAX, aat_pkg::SIZE_MAX));
    pending_boxes.push_back(make_box(24'sd1, 24'sd1, 24'sd1, 23'd1, 23'd1, 23'd1));
    pending_boxes.push_back(make_box('0, '0, '0, aat_pkg::SIZE_MAX, '0, '0));
    wait_drained();

    // random boxes under random settings
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin
        send_idle_pct = 61;
        recv_idle_pct = 14;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_random_config();
      // sender keeps offering while the receiver holds off
      if (phase == 4) pressure_on = 1'b1;
      run_random(RANDOM_BOXES);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    #1;
    if (expected_boxes.size() != 0) begin
      $error("%0d expected results never arrived", expected_boxes.size());
      fail_count++;
    end
    $display("Transformed %0d boxes (%0d checked) under %0d register settings,",
             boxes_in, boxes_out, config_sets);
    $display("with sender and receiver idling and %0d cycles of input backpressure.",
             stall_cycles);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
